FILE: hdl/xosm_pkg.sv
// shared definitions for the xor order statistic multiset unit
// request codes, status codes, sequencer states and default sizes
// no dependencies
`default_nettype none
package xosm_pkg;

  localparam int KEY_BITS_DEF   = 10;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [3:0] REQ_ADD     = 4'd0;
  localparam logic [3:0] REQ_DISCARD = 4'd1;
  localparam logic [3:0] REQ_COUNT   = 4'd2;
  localparam logic [3:0] REQ_KTH     = 4'd3;
  localparam logic [3:0] REQ_POP     = 4'd4;
  localparam logic [3:0] REQ_RANK_LT = 4'd5;
  localparam logic [3:0] REQ_RANK_LE = 4'd6;
  localparam logic [3:0] REQ_MIN     = 4'd7;
  localparam logic [3:0] REQ_MAX     = 4'd8;
  localparam logic [3:0] REQ_XOR     = 4'd9;
  localparam logic [3:0] REQ_GT      = 4'd10;
  localparam logic [3:0] REQ_LT      = 4'd11;
  localparam logic [3:0] REQ_GE      = 4'd12;
  localparam logic [3:0] REQ_LE      = 4'd13;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_LEAF_RD = 11'b000_0000_0010,
    S_LEAF_WT = 11'b000_0000_0100,
    S_RANK_RD = 11'b000_0000_1000,
    S_RANK_WT = 11'b000_0001_0000,
    S_NBR     = 11'b000_0010_0000,
    S_SEL_RD  = 11'b000_0100_0000,
    S_SEL_WT  = 11'b000_1000_0000,
    S_ADJ_RD  = 11'b001_0000_0000,
    S_ADJ_WT  = 11'b010_0000_0000,
    S_OUT     = 11'b100_0000_0000
  } state_t;

endpackage
`default_nettype wire

FILE: hdl/xor_order_statistic_multiset_unit.sv
// xor order statistic multiset: top level with request sequencer and shared adder
// depends on xosm_pkg and xosm_tree
`default_nettype none
// usage
//   in_* channel carries one request item; out_* channel returns one result item
//   per request. both are valid/ready channels, an item moves when tvalid and
//   tready are high at a rising edge.
//   keys live in a binary tree of counts in one memory; each tree walk goes
//   level by level through a single shared add/subtract unit.
// sequence per request (each tree level reads memory before it adds)
//   xor or unused code: straight to the result; count: leaf read; add/discard:
//   leaf read, then an update walk to the root; kth, min, max: select walk,
//   pop adds an update walk; rank lt: rank walk; neighbour: rank walk, then select walk
//   one request at a time: in_tready is low from accept until the result is taken
// reset
//   synchronous active low; afterwards the store is cleared by a pass over
//   all 2^(KB+1) nodes (2048 at default size) during which in_tready stays low
// stall
//   the result sits in output registers until out_tready; no new item is taken
//   meanwhile
module xor_order_statistic_multiset_unit #(
  parameter int KEY_BITS   = xosm_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = xosm_pkg::COUNT_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // req_type(4), key(KEY_BITS), amount(COUNT_BITS), rank(COUNT_BITS+1), xor_mask(KEY_BITS)
  input  wire logic [((4 + 2*KEY_BITS + 2*COUNT_BITS + 1 + 7) / 8) * 8 - 1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // status(2), value(KEY_BITS), tally(COUNT_BITS), total(COUNT_BITS)
  output logic [((2 + KEY_BITS + 2*COUNT_BITS + 7) / 8) * 8 - 1:0] out_tdata
);
  localparam int KW = KEY_BITS;
  localparam int CW = COUNT_BITS;
  localparam int AW = KW + 1;
  localparam int LW = (KW > 1) ? $clog2(KW) : 1;
  localparam int OW = ((2 + KW + 2*CW + 7) / 8) * 8;

  // input fields
  logic [3:0]    in_req;
  logic [KW-1:0] in_key;
  logic [CW-1:0] in_amount;
  logic [CW:0]   in_rank;
  logic [KW-1:0] in_xor;

  assign in_req    = in_tdata[3:0];
  assign in_key    = in_tdata[4 +: KW];
  assign in_amount = in_tdata[4 + KW +: CW];
  assign in_rank   = in_tdata[4 + KW + CW +: CW + 1];
  assign in_xor    = in_tdata[5 + KW + 2*CW +: KW];

  xosm_pkg::state_t state_r, state_nxt;
  logic [3:0]    req_r, req_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic [CW-1:0] amount_r, amount_nxt;
  logic [KW-1:0] mask_r, mask_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [CW-1:0] acc_r, acc_nxt;      // rank accumulator, or remaining rank in select
  logic [CW-1:0] delta_r, delta_nxt;
  logic          up_r, up_nxt;
  logic [AW-1:0] node_r, node_nxt;
  logic [KW-1:0] res_r, res_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [AW-1:0] adj_addr_r, adj_addr_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [KW-1:0] value_r, value_nxt;
  logic [CW-1:0] tally_r, tally_nxt;

  // shared add / subtract unit operands and result
  logic [CW-1:0] sa, sb;
  logic          sub;
  logic [CW:0]   sum;

  // tree memory
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] rd_data;
  logic          wr_en;
  logic          clr_busy;

  xosm_tree #(
    .KEY_BITS  (KEY_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_tree (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(adj_addr_r),
    .wr_data(sum[CW-1:0]),
    .busy   (clr_busy)
  );

  logic in_fire;
  assign in_tready = (state_r == xosm_pkg::S_IDLE) && !clr_busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = (state_r == xosm_pkg::S_OUT);
  assign out_tdata  = OW'({total_r, tally_r, value_r, status_r});

  // rank normalization: negative rank counts back from the total
  logic [CW+1:0] rank_n;
  logic          rank_ok;
  always_comb begin
    if (in_rank[CW]) rank_n = {in_rank[CW], in_rank} + {2'b00, total_r};
    else             rank_n = {1'b0, in_rank};
    rank_ok = !rank_n[CW+1] && (rank_n[CW:0] < {1'b0, total_r});
  end

  // current key bit and mask bit of the walk
  logic kb, mb;
  assign kb = key_r[lvl_r];
  assign mb = mask_r[lvl_r];

  // shared add / subtract unit; with sub set, carry means sa >= sb
  always_comb begin
    sa  = '0;
    sb  = '0;
    sub = 1'b0;
    case (state_r)
      xosm_pkg::S_IDLE: begin
        sa = total_r;
        if (in_req == xosm_pkg::REQ_MAX) begin
          sb  = CW'(1);
          sub = 1'b1;
        end else begin
          sb = in_amount;
        end
      end
      xosm_pkg::S_LEAF_WT: begin
        case (req_r)
          xosm_pkg::REQ_ADD: begin
            sa = rd_data;
            sb = (status_r == xosm_pkg::ST_RANGE) ? '0 : amount_r;
          end
          xosm_pkg::REQ_DISCARD: begin
            sa  = rd_data;
            sb  = amount_r;
            sub = 1'b1;
          end
          default: begin
            sa = acc_r;
            sb = rd_data;
          end
        endcase
      end
      xosm_pkg::S_RANK_WT: begin
        sa = acc_r;
        sb = kb ? rd_data : '0;
      end
      xosm_pkg::S_NBR: begin
        sa  = acc_r;
        sb  = (req_r == xosm_pkg::REQ_GT || req_r == xosm_pkg::REQ_GE) ? total_r : CW'(1);
        sub = 1'b1;
      end
      xosm_pkg::S_SEL_WT: begin
        sa  = acc_r;
        sb  = rd_data;
        sub = 1'b1;
      end
      xosm_pkg::S_ADJ_WT: begin
        sa  = rd_data;
        sb  = delta_r;
        sub = !up_r;
      end
      default: begin
        sa = '0;
      end
    endcase
    sum = {1'b0, sa} + {1'b0, sub ? ~sb : sb} + {{CW{1'b0}}, sub};
  end

  // memory read address per phase
  always_comb begin
    case (state_r)
      xosm_pkg::S_LEAF_RD: rd_addr = {1'b1, key_r ^ mask_r};
      xosm_pkg::S_RANK_RD: rd_addr = {node_r[KW-1:0], mb};
      xosm_pkg::S_SEL_RD:  rd_addr = {node_r[KW-1:0], mb};
      default:             rd_addr = adj_addr_r;
    endcase
  end

  assign wr_en = (state_r == xosm_pkg::S_ADJ_WT);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    key_nxt      = key_r;
    amount_nxt   = amount_r;
    mask_nxt     = mask_r;
    total_nxt    = total_r;
    acc_nxt      = acc_r;
    delta_nxt    = delta_r;
    up_nxt       = up_r;
    node_nxt     = node_r;
    res_nxt      = res_r;
    lvl_nxt      = lvl_r;
    adj_addr_nxt = adj_addr_r;
    status_nxt   = status_r;
    value_nxt    = value_r;
    tally_nxt    = tally_r;
    case (state_r)
      xosm_pkg::S_IDLE: begin
        if (in_fire) begin
          req_nxt      = in_req;
          key_nxt      = in_key;
          amount_nxt   = in_amount;
          acc_nxt      = '0;
          node_nxt     = AW'(1);
          res_nxt      = '0;
          lvl_nxt      = LW'(KW - 1);
          adj_addr_nxt = {1'b1, in_key ^ mask_r};
          status_nxt   = xosm_pkg::ST_OK;
          value_nxt    = '0;
          tally_nxt    = '0;
          case (in_req)
            xosm_pkg::REQ_ADD: begin
              if (sum[CW]) status_nxt = xosm_pkg::ST_RANGE;
              state_nxt = xosm_pkg::S_LEAF_RD;
            end
            xosm_pkg::REQ_DISCARD, xosm_pkg::REQ_COUNT: begin
              state_nxt = xosm_pkg::S_LEAF_RD;
            end
            xosm_pkg::REQ_KTH, xosm_pkg::REQ_POP: begin
              if (!rank_ok) begin
                status_nxt = xosm_pkg::ST_RANGE;
                state_nxt  = xosm_pkg::S_OUT;
              end else begin
                acc_nxt   = rank_n[CW-1:0];
                tally_nxt = rank_n[CW-1:0];
                state_nxt = xosm_pkg::S_SEL_RD;
              end
            end
            xosm_pkg::REQ_RANK_LT, xosm_pkg::REQ_RANK_LE, xosm_pkg::REQ_GT,
            xosm_pkg::REQ_LT, xosm_pkg::REQ_GE, xosm_pkg::REQ_LE: begin
              state_nxt = xosm_pkg::S_RANK_RD;
            end
            xosm_pkg::REQ_MIN, xosm_pkg::REQ_MAX: begin
              if (total_r == '0) begin
                status_nxt = xosm_pkg::ST_ABSENT;
                state_nxt  = xosm_pkg::S_OUT;
              end else begin
                if (in_req == xosm_pkg::REQ_MAX) begin
                  acc_nxt   = sum[CW-1:0];
                  tally_nxt = sum[CW-1:0];
                end
                state_nxt = xosm_pkg::S_SEL_RD;
              end
            end
            xosm_pkg::REQ_XOR: begin
              mask_nxt  = mask_r ^ in_xor;
              state_nxt = xosm_pkg::S_OUT;
            end
            default: begin
              state_nxt = xosm_pkg::S_OUT;
            end
          endcase
        end
      end
      xosm_pkg::S_LEAF_RD: state_nxt = xosm_pkg::S_LEAF_WT;
      xosm_pkg::S_LEAF_WT: begin
        state_nxt = xosm_pkg::S_OUT;
        case (req_r)
          xosm_pkg::REQ_ADD: begin
            tally_nxt = sum[CW-1:0];
            if (status_r == xosm_pkg::ST_OK && amount_r != '0) begin
              delta_nxt = amount_r;
              up_nxt    = 1'b1;
              state_nxt = xosm_pkg::S_ADJ_RD;
            end
          end
          xosm_pkg::REQ_DISCARD: begin
            if (rd_data == '0) begin
              status_nxt = xosm_pkg::ST_ABSENT;
            end else begin
              // remove all copies when fewer than asked are held
              if (sum[CW]) begin
                tally_nxt = sum[CW-1:0];
                delta_nxt = amount_r;
              end else begin
                tally_nxt = '0;
                delta_nxt = rd_data;
              end
              up_nxt    = 1'b0;
              state_nxt = xosm_pkg::S_ADJ_RD;
            end
          end
          xosm_pkg::REQ_COUNT:   tally_nxt = rd_data;
          xosm_pkg::REQ_RANK_LE: tally_nxt = sum[CW-1:0];
          xosm_pkg::REQ_GT, xosm_pkg::REQ_LE: begin
            acc_nxt   = sum[CW-1:0];
            state_nxt = xosm_pkg::S_NBR;
          end
          default: state_nxt = xosm_pkg::S_OUT;
        endcase
      end
      xosm_pkg::S_RANK_RD: state_nxt = xosm_pkg::S_RANK_WT;
      xosm_pkg::S_RANK_WT: begin
        acc_nxt  = sum[CW-1:0];
        node_nxt = {node_r[KW-1:0], kb ^ mb};
        if (lvl_r == '0) begin
          lvl_nxt = LW'(KW - 1);
          node_nxt = AW'(1);
          case (req_r)
            xosm_pkg::REQ_RANK_LT: begin
              tally_nxt = sum[CW-1:0];
              state_nxt = xosm_pkg::S_OUT;
            end
            xosm_pkg::REQ_GE, xosm_pkg::REQ_LT: state_nxt = xosm_pkg::S_NBR;
            default:                            state_nxt = xosm_pkg::S_LEAF_RD;
          endcase
        end else begin
          lvl_nxt   = lvl_r - 1'b1;
          state_nxt = xosm_pkg::S_RANK_RD;
        end
      end
      xosm_pkg::S_NBR: begin
        if (req_r == xosm_pkg::REQ_GT || req_r == xosm_pkg::REQ_GE) begin
          if (sum[CW]) begin
            status_nxt = xosm_pkg::ST_ABSENT;
            state_nxt  = xosm_pkg::S_OUT;
          end else begin
            tally_nxt = acc_r;
            state_nxt = xosm_pkg::S_SEL_RD;
          end
        end else begin
          if (!sum[CW]) begin
            status_nxt = xosm_pkg::ST_ABSENT;
            state_nxt  = xosm_pkg::S_OUT;
          end else begin
            acc_nxt   = sum[CW-1:0];
            tally_nxt = sum[CW-1:0];
            state_nxt = xosm_pkg::S_SEL_RD;
          end
        end
      end
      xosm_pkg::S_SEL_RD: state_nxt = xosm_pkg::S_SEL_WT;
      xosm_pkg::S_SEL_WT: begin
        // go right when the remaining rank is not below the left count
        if (sum[CW]) acc_nxt = sum[CW-1:0];
        node_nxt       = {node_r[KW-1:0], mb ^ sum[CW]};
        res_nxt[lvl_r] = sum[CW];
        if (lvl_r == '0) begin
          value_nxt = res_nxt;
          if (req_r == xosm_pkg::REQ_POP) begin
            adj_addr_nxt = {1'b1, res_nxt ^ mask_r};
            delta_nxt    = CW'(1);
            up_nxt       = 1'b0;
            state_nxt    = xosm_pkg::S_ADJ_RD;
          end else begin
            state_nxt = xosm_pkg::S_OUT;
          end
        end else begin
          lvl_nxt   = lvl_r - 1'b1;
          state_nxt = xosm_pkg::S_SEL_RD;
        end
      end
      xosm_pkg::S_ADJ_RD: state_nxt = xosm_pkg::S_ADJ_WT;
      xosm_pkg::S_ADJ_WT: begin
        if (adj_addr_r == AW'(1)) begin
          total_nxt = sum[CW-1:0];
          state_nxt = xosm_pkg::S_OUT;
        end else begin
          adj_addr_nxt = adj_addr_r >> 1;
          state_nxt    = xosm_pkg::S_ADJ_RD;
        end
      end
      xosm_pkg::S_OUT: begin
        if (out_tready) state_nxt = xosm_pkg::S_IDLE;
      end
      default: state_nxt = xosm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xosm_pkg::S_IDLE;
      mask_r  <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      mask_r  <= mask_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    key_r      <= key_nxt;
    amount_r   <= amount_nxt;
    acc_r      <= acc_nxt;
    delta_r    <= delta_nxt;
    up_r       <= up_nxt;
    node_r     <= node_nxt;
    res_r      <= res_nxt;
    lvl_r      <= lvl_nxt;
    adj_addr_r <= adj_addr_nxt;
    status_r   <= status_nxt;
    value_r    <= value_nxt;
    tally_r    <= tally_nxt;
  end

  // checks
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("item taken while a request is in work");

  a_no_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a result waits");

  a_write_only_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !in_tready && !out_tvalid)
    else $error("tree written outside an update walk");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (status_r == xosm_pkg::ST_OK || status_r == xosm_pkg::ST_ABSENT ||
                    status_r == xosm_pkg::ST_RANGE))
    else $error("bad status code");

endmodule
`default_nettype wire

FILE: hdl/xosm_tree.sv
// count tree storage: one write port, one registered read port
// runs a clearing pass over every node after reset; depends on xosm_pkg
`default_nettype none
module xosm_tree #(
  parameter int KEY_BITS   = xosm_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = xosm_pkg::COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [KEY_BITS:0]     rd_addr,
  output logic      [COUNT_BITS-1:0] rd_data,
  input  wire logic                  wr_en,
  input  wire logic [KEY_BITS:0]     wr_addr,
  input  wire logic [COUNT_BITS-1:0] wr_data,
  output logic                       busy
);
  localparam int AW    = KEY_BITS + 1;
  localparam int DEPTH = 2 ** AW;

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [AW-1:0]         clr_cnt_r;
  logic                  clr_busy_r;
  logic [COUNT_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == {AW{1'b1}}) clr_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule
`default_nettype wire

FILE: tb/sv/tb_xor_order_statistic_multiset_unit.sv
// self-checking bench for the xor order statistic multiset unit
// drives request items, predicts every result from a local count tree, checks each field
// depends on xosm_pkg and the unit's rtl
`default_nettype none
module tb_xor_order_statistic_multiset_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KB = xosm_pkg::KEY_BITS_DEF;
  localparam int CB = xosm_pkg::COUNT_BITS_DEF;
  localparam int LEAF = 1 << KB;
  localparam int CMAX = (1 << CB) - 1;
  localparam int N_RANDOM = 1630;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // req_type, key, amount, rank, xor_mask, zero fill (lowest bit first)
  logic [63:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // status, value, tally, total, zero fill (lowest bit first)
  logic [47:0] out_tdata;

  xor_order_statistic_multiset_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic [15:0] total;
    logic [15:0] tally;
    logic [9:0]  value;
    logic [1:0]  status;
  } answer_t;

  logic [63:0] request_q[$];
  answer_t     answer_q[$];
  int unsigned counts[2*LEAF];   // model count tree, node 1 is the root
  logic [KB-1:0] mask_bits;
  int failures = 0;
  int results_seen = 0;
  bit in_taken = 1'b0;
  bit gen_done = 1'b0;

  function automatic logic [63:0] pack_req(logic [3:0] req, logic [9:0] key,
                                           logic [15:0] amount, logic [16:0] rank,
                                           logic [9:0] xm);
    return {7'd0, xm, rank, amount, key, req};
  endfunction

  function automatic int unsigned leaf_of(logic [KB-1:0] key);
    return counts[LEAF + int'(key ^ mask_bits)];
  endfunction

  function automatic void walk_adjust(logic [KB-1:0] key, int unsigned delta, bit up);
    int unsigned node;
    node = LEAF + int'(key ^ mask_bits);
    while (node >= 1) begin
      if (up) counts[node] += delta;
      else counts[node] -= delta;
      node >>= 1;
    end
  endfunction

  function automatic int unsigned count_below(logic [KB-1:0] key);
    int unsigned node, acc;
    node = 1;
    acc = 0;
    for (int b = KB - 1; b >= 0; b--) begin
      if (key[b]) acc += counts[2*node + mask_bits[b]];
      node = 2*node + (key[b] ^ mask_bits[b]);
    end
    return acc;
  endfunction

  function automatic logic [KB-1:0] key_at(int unsigned r);
    int unsigned node, t;
    logic [KB-1:0] res;
    node = 1;
    res = '0;
    for (int b = KB - 1; b >= 0; b--) begin
      t = counts[2*node + mask_bits[b]];
      if (r < t) begin
        node = 2*node + mask_bits[b];
      end else begin
        r -= t;
        res[b] = 1'b1;
        node = 2*node + (mask_bits[b] ^ 1'b1);
      end
    end
    return res;
  endfunction

  // applies one request to the model tree and returns the answer it should give
  function automatic answer_t apply_request(logic [63:0] item);
    logic [3:0] req;
    logic [KB-1:0] key;
    int unsigned amount, total, c, i;
    longint r;
    answer_t a;
    req = item[3:0];
    key = item[13:4];
    amount = item[29:14];
    r = longint'($signed(item[46:30]));
    total = counts[1];
    a = '0;
    case (req)
      xosm_pkg::REQ_ADD: begin
        if (total + amount > CMAX) a.status = xosm_pkg::ST_RANGE;
        else if (amount != 0) walk_adjust(key, amount, 1'b1);
        a.tally = 16'(leaf_of(key));
      end
      xosm_pkg::REQ_DISCARD: begin
        c = leaf_of(key);
        if (c == 0) a.status = xosm_pkg::ST_ABSENT;
        else walk_adjust(key, amount < c ? amount : c, 1'b0);
        a.tally = 16'(leaf_of(key));
      end
      xosm_pkg::REQ_COUNT: a.tally = 16'(leaf_of(key));
      xosm_pkg::REQ_KTH, xosm_pkg::REQ_POP: begin
        if (r < 0) r += total;
        if (r < 0 || r >= total) begin
          a.status = xosm_pkg::ST_RANGE;
        end else begin
          a.value = key_at(32'(r));
          a.tally = 16'(r);
          if (req == xosm_pkg::REQ_POP) walk_adjust(a.value, 1, 1'b0);
        end
      end
      xosm_pkg::REQ_RANK_LT: a.tally = 16'(count_below(key));
      xosm_pkg::REQ_RANK_LE: a.tally = 16'(count_below(key) + leaf_of(key));
      xosm_pkg::REQ_MIN, xosm_pkg::REQ_MAX: begin
        if (total == 0) begin
          a.status = xosm_pkg::ST_ABSENT;
        end else begin
          i = (req == xosm_pkg::REQ_MIN) ? 0 : total - 1;
          a.value = key_at(i);
          a.tally = 16'(i);
        end
      end
      xosm_pkg::REQ_XOR: mask_bits ^= item[56:47];
      xosm_pkg::REQ_GT, xosm_pkg::REQ_GE: begin
        i = count_below(key);
        if (req == xosm_pkg::REQ_GT) i += leaf_of(key);
        if (i >= total) begin
          a.status = xosm_pkg::ST_ABSENT;
        end else begin
          a.value = key_at(i);
          a.tally = 16'(i);
        end
      end
      xosm_pkg::REQ_LT, xosm_pkg::REQ_LE: begin
        i = count_below(key);
        if (req == xosm_pkg::REQ_LE) i += leaf_of(key);
        if (i == 0) begin
          a.status = xosm_pkg::ST_ABSENT;
        end else begin
          a.value = key_at(i - 1);
          a.tally = 16'(i - 1);
        end
      end
      default: ;
    endcase
    a.total = 16'(counts[1]);
    return a;
  endfunction

  // no idling while the middle band of results goes by
  function automatic bit take_break();
    if (results_seen >= 600 && results_seen < 900) return 1'b0;
    return $urandom_range(99) < 14;
  endfunction

  // stimulus: directed corners first, then random requests, keys mostly from a small key pool
  initial begin
    logic [9:0] pool[16];
    logic [3:0] req;
    logic [9:0] key;
    logic [15:0] amount;
    logic [16:0] rank;
    int sel;
    foreach (pool[k]) pool[k] = 10'($urandom_range(1023));
    pool[0] = 10'd0;
    pool[1] = 10'h3ff;
    // empty store corners
    request_q.push_back(pack_req(xosm_pkg::REQ_MIN, 0, 0, 0, 0));
    request_q.push_back(pack_req(xosm_pkg::REQ_MAX, 0, 0, 0, 0));
    request_q.push_back(pack_req(xosm_pkg::REQ_KTH, 0, 0, 0, 0));
    request_q.push_back(pack_req(xosm_pkg::REQ_DISCARD, 10'h155, 5, 0, 0));
    request_q.push_back(pack_req(xosm_pkg::REQ_GT, 0, 0, 0, 0));
    request_q.push_back(pack_req(xosm_pkg::REQ_LE, 10'h3ff, 0, 0, 0));
    // filling, zero amount, extremes of key
    request_q.push_back(pack_req(xosm_pkg::REQ_ADD, 10'h000, 3, 0, 0));
    request_q.push_back(pack_req(xosm_pkg::REQ_ADD, 10'h3ff, 16'hffff, 0, 0));
    request_q.push_back(pack_req(xosm_pkg::REQ_ADD, 10'h3ff, 16'hfff0, 0, 0));
    request_q.push_back(pack_req(xosm_pkg::REQ_ADD, 10'h2aa, 0, 0, 0));
    request_q.push_back(pack_req(xosm_pkg::REQ_RANK_LE, 10'h3ff, 0, 0, 0));
    request_q.push_back(pack_req(xosm_pkg::REQ_RANK_LT, 10'h3ff, 0, 0, 0));
    request_q.push_back(pack_req(xosm_pkg::REQ_KTH, 0, 0, 17'h1ffff, 0));
    request_q.push_back(pack_req(xosm_pkg::REQ_KTH, 0, 0, 17'h10000, 0));
    request_q.push_back(pack_req(xosm_pkg::REQ_POP, 0, 0, 17'h0ffff, 0));
    request_q.push_back(pack_req(xosm_pkg::REQ_DISCARD, 10'h3ff, 16'hffff, 0, 0));
    request_q.push_back(pack_req(xosm_pkg::REQ_XOR, 0, 0, 0, 10'h3ff));
    request_q.push_back(pack_req(xosm_pkg::REQ_ADD, 10'h0f0, 2, 0, 0));
    request_q.push_back(pack_req(xosm_pkg::REQ_MIN, 0, 0, 0, 0));
    request_q.push_back(pack_req(xosm_pkg::REQ_MAX, 0, 0, 0, 0));
    request_q.push_back(pack_req(xosm_pkg::REQ_GE, 10'h0f0, 0, 0, 0));
    request_q.push_back(pack_req(xosm_pkg::REQ_LT, 10'h0f0, 0, 0, 0));
    request_q.push_back(pack_req(xosm_pkg::REQ_COUNT, 10'h0f0, 0, 0, 0));
    request_q.push_back(pack_req(4'd14, 10'h3ff, 16'hffff, 17'h1ffff, 10'h3ff));
    request_q.push_back(pack_req(4'd15, 0, 0, 0, 0));
    for (int n = 0; n < N_RANDOM; n++) begin
      req = 4'($urandom_range(15));
      if ($urandom_range(3) == 0) req = 4'($urandom_range(1));   // keep the store busy
      key = ($urandom_range(9) == 0) ? 10'($urandom) : pool[$urandom_range(15)];
      sel = $urandom_range(99);
      if (sel < 5) amount = 16'($urandom);
      else if (sel < 8) amount = 16'hffff - 16'($urandom_range(50));
      else amount = 16'($urandom_range(20));
      sel = $urandom_range(99);
      if (sel < 10) rank = 17'($urandom);
      else if (sel < 40) rank = -17'($urandom_range(1, 60));
      else rank = 17'($urandom_range(80));
      request_q.push_back(pack_req(req, key, amount, rank, 10'($urandom)));
    end
    gen_done = 1'b1;
  end

  // reset once, released at a falling edge
  initial begin
    foreach (counts[k]) counts[k] = 0;
    mask_bits = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // driver: new item or idle at the falling edge once the last one was taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        in_taken = 1'b0;
        if (gen_done && request_q.size() > 0 && !take_break()) begin
          in_tdata <= request_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= !take_break();
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    answer_t got, want;
    if (rst_n && in_tvalid && in_tready) begin
      answer_q.push_back(apply_request(in_tdata));
      in_taken = 1'b1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[43:0];
      results_seen++;
      if (answer_q.size() == 0) begin
        $error("result item with nothing expected: %h", out_tdata);
        failures++;
      end else begin
        want = answer_q.pop_front();
        if (got.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status);
          failures++;
        end
        if (got.value !== want.value) begin
          $error("value expected %0d actual %0d", want.value, got.value);
          failures++;
        end
        if (got.tally !== want.tally) begin
          $error("tally expected %0d actual %0d", want.tally, got.tally);
          failures++;
        end
        if (got.total !== want.total) begin
          $error("total expected %0d actual %0d", want.total, got.total);
          failures++;
        end
      end
    end
  end

  // end of run: everything sent and answered, then a short drain
  initial begin
    wait (gen_done && rst_n);
    wait (request_q.size() == 0 && !in_tvalid && answer_q.size() == 0);
    repeat (200) @(posedge clk);
    if (failures == 0 && answer_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
